FILE: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// shared types, constants and step tables for the md5 digest block
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // request passed from front to back
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } md5_req_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index for step i
  function automatic logic [3:0] word_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(({2'b0, i[3:0]} * 6'd5) + 6'd1);
      2'd2: g = 4'(({2'b0, i[3:0]} * 6'd3) + 6'd5);
      default: g = 4'({2'b0, i[3:0]} * 6'd7);
    endcase
    return g;
  endfunction

endpackage

FILE: sv/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// input stage and short request queue in front of the digest engine
// ----------------------------------------------------------------------------
module md5_front
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  md5_req_t in_req,
  output logic     q_valid,
  input  logic     q_ready,
  output md5_req_t q_req
);

  md5_req_t   slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic       push, pop;

  assign in_ready = (fill != 3'd4);
  assign q_valid  = (fill != 3'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_req    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= in_req;
        wr_ptr        <= wr_ptr + 2'd1;
      end
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

FILE: sv/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back
// block buffer, padding sequencer and one-step-per-cycle md5 round engine
// ----------------------------------------------------------------------------
module md5_back
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_ready,
  input  md5_req_t     q_req,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_digest
);

  typedef enum logic [2:0] {S_IDLE, S_COMP, S_PAD, S_LEN, S_DONE} state_t;

  state_t      state;
  logic [31:0] buf_words [16];  // block buffer, four bytes per word, little-endian
  logic [31:0] byte_count;
  logic [5:0]  pos;
  logic [5:0]  step;
  logic [31:0] ha, hb, hc, hd;
  logic [31:0] a, b, c, d;
  logic        finishing;   // padding in progress
  logic        last_block;  // current compression closes the message
  logic        busy_len;    // length field reached, held until done
  logic [31:0] m_word;
  logic [31:0] f, sum, rot;
  logic [3:0]  g;
  logic [63:0] bit_len;

  assign q_ready = (state == S_IDLE) && !out_valid;
  assign bit_len = {29'b0, byte_count, 3'b0};

  assign g      = word_g(step);
  assign m_word = buf_words[g];

  always_comb begin
    case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + sine_k(step) + m_word;
    rot = (sum << shift_s(step)) | (sum >> (6'd32 - {1'b0, shift_s(step)}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      pos        <= '0;
      step       <= '0;
      ha <= INIT_A; hb <= INIT_B; hc <= INIT_C; hd <= INIT_D;
      out_valid  <= 1'b0;
      finishing  <= 1'b0;
      last_block <= 1'b0;
      busy_len   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_req.kind == KIND_BYTE) begin
              buf_words[pos[5:2]][{pos[1:0], 3'b0} +: 8] <= q_req.data;
              byte_count   <= byte_count + 32'd1;
              pos          <= pos + 6'd1;
              if (pos == 6'd63) begin
                a <= ha; b <= hb; c <= hc; d <= hd;
                step  <= '0;
                state <= S_COMP;
              end
            end else begin
              buf_words[pos[5:2]][{pos[1:0], 3'b0} +: 8] <= PAD_BYTE;
              pos          <= pos + 6'd1;
              finishing    <= 1'b1;
              // pad byte closes the block: compress it before the zero fill
              if (pos == 6'd63) begin
                a <= ha; b <= hb; c <= hc; d <= hd;
                step  <= '0;
                state <= S_COMP;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          // zero fill up to the length field, or to the block end if past it
          if (pos == 6'd56 && !busy_len) begin
            busy_len <= 1'b1;
            state    <= S_LEN;
          end else begin
            buf_words[pos[5:2]][{pos[1:0], 3'b0} +: 8] <= 8'h00;
            pos          <= pos + 6'd1;
            if (pos == 6'd63) begin
              a <= ha; b <= hb; c <= hc; d <= hd;
              step  <= '0;
              state <= S_COMP;
            end
          end
        end
        S_LEN: begin
          buf_words[pos[5:2]][{pos[1:0], 3'b0} +: 8] <= bit_len[{pos[2:0], 3'b0} +: 8];
          pos          <= pos + 6'd1;
          if (pos == 6'd63) begin
            a <= ha; b <= hb; c <= hc; d <= hd;
            step       <= '0;
            last_block <= 1'b1;
            state      <= S_COMP;
          end
        end
        S_COMP: begin
          a <= d; d <= c; c <= b;
          b <= b + rot;
          step <= step + 6'd1;
          if (step == 6'd63) begin
            ha <= ha + d;
            hb <= hb + b + rot;
            hc <= hc + b;
            hd <= hd + c;
            if (last_block) state <= S_DONE;
            else if (finishing) state <= S_PAD;
            else state <= S_IDLE;
          end
        end
        S_DONE: begin
          out_digest <= {hd, hc, hb, ha};
          out_valid  <= 1'b1;
          ha <= INIT_A; hb <= INIT_B; hc <= INIT_C; hd <= INIT_D;
          byte_count <= '0;
          pos        <= '0;
          finishing  <= 1'b0;
          last_block <= 1'b0;
          busy_len   <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/md5_message_digest.sv
// ----------------------------------------------------------------------------
// md5_message_digest
// streaming md5 digest: bytes in, 128-bit digest out on finish
// ----------------------------------------------------------------------------
// Message bytes enter one request per cycle into a four-deep queue while it
// has room; the back end stores each byte into the 64-byte block buffer.
// Every 64th byte starts the round engine, which does one md5 step per
// cycle. A finish request writes 0x80, zero fill and the 64-bit bit length
// byte by byte and compresses one or two blocks, then presents the digest
// words a..d in m_tdata and returns to initial state.
// The queue keeps accepting bytes while the engine runs until it fills.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // kind: 0 byte, 1 finish
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // digest_word_a, b, c, d from the lowest bit up
);

  md5_req_t in_req, q_req;
  logic     q_valid, q_ready;

  assign in_req = '{kind: s_tuser, data: s_tdata};

  // front end: accept and buffer requests
  md5_front u_front (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready), .in_req (in_req),
    .q_valid, .q_ready, .q_req
  );

  // back end: buffer, pad and compress
  md5_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_req,
    .out_valid (m_tvalid), .out_ready (m_tready), .out_digest (m_tdata)
  );

endmodule

FILE: dv/md5_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// follows the byte and finish requests into the digest block, computes the
// md5 digest of every message and compares it with each digest that leaves
// ----------------------------------------------------------------------------
module md5_digest_checker
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  output int           fail_count,
  output int           digests_pending
);

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int ROT_AMOUNT [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                       '{4, 11, 16, 23}, '{6, 10, 15, 21}};

  logic [31:0]  chain [4];
  logic [7:0]   block [64];
  logic [31:0]  msg_len;
  logic [127:0] digest_q [$];

  function automatic logic [31:0] rotl(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, sum;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      sum = a + f + ROUND_CONST[i] + w[g];
      a = d; d = c; c = b;
      b = b + rotl(sum, ROT_AMOUNT[i / 16][i % 4]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic start_message();
    chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
    msg_len = '0;
  endtask

  // pad, append length and queue the digest
  task automatic finish_message();
    int pos;
    logic [63:0] bit_len;
    pos = msg_len[5:0];
    block[pos++] = PAD_BYTE;
    if (pos > 56) begin
      while (pos < 64) block[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < 56) block[pos++] = 8'h00;
    bit_len = {29'b0, msg_len, 3'b0};
    for (int i = 0; i < 8; i++) block[56+i] = bit_len[8*i +: 8];
    compress();
    digest_q.push_back({chain[3], chain[2], chain[1], chain[0]});
    start_message();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h want %08h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    start_message();
  end

  assign digests_pending = digest_q.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser == KIND_FINISH) begin
        finish_message();
      end else begin
        block[msg_len[5:0]] = s_tdata;
        msg_len++;
        if (msg_len[5:0] == 6'd0) compress();
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("unexpected digest %032h", m_tdata);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] != want[31:0]) report("word a", m_tdata[31:0], want[31:0]);
        if (m_tdata[63:32] != want[63:32]) report("word b", m_tdata[63:32], want[63:32]);
        if (m_tdata[95:64] != want[95:64]) report("word c", m_tdata[95:64], want[95:64]);
        if (m_tdata[127:96] != want[127:96])
          report("word d", m_tdata[127:96], want[127:96]);
      end
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives messages of many lengths into the md5 digest block with random
// idling on both sides; the checker computes and compares every digest
// ----------------------------------------------------------------------------
module tb;
  import md5_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;    // data_byte
  logic         s_tuser = 1'b0;  // kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;         // digest words a, b, c, d from the lowest bit up
  int           fail_count;
  int           digests_pending;
  bit           calm = 1'b0;     // no idling in the last part of the run
  int           idle_cycles = 0;
  int           sink_idle = 0;

  always #2 clk = ~clk;

  md5_message_digest dut (.*);

  md5_digest_checker chk (.*);

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (sink_idle > 0) begin
      sink_idle <= sink_idle - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_idle <= $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one request, with an occasional sender gap before it
  task automatic send(logic kind, logic [7:0] data);
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message(int len, int fill_mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: b = $urandom_range(0, 255);
        1: b = 8'h00;
        2: b = 8'hff;
        default: b = 8'(i);
      endcase
      send(KIND_BYTE, b);
    end
    send(KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int sent;
    int len;
    bit drained;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: empty message, padding boundaries, extreme bytes
    send_message(0, 0);
    send_message(1, 1);
    send_message(1, 2);
    send_message(3, 3);
    send_message(55, 0);
    send_message(56, 2);
    send_message(63, 0);
    send_message(64, 1);
    send_message(65, 3);
    send(KIND_FINISH, 8'hff);
    send(KIND_FINISH, 8'h00);
    sent = 0;
    drained = 1'b0;
    // random messages, mostly short
    while (sent < 930) begin
      if (sent > 750) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 66);
        1: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 20);
      endcase
      send_message(len, ($urandom_range(0, 7) == 0) ? 2 : 0);
      sent += len + 1;
      // drain everything once mid run
      if (!drained && sent > 450) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        while (digests_pending != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (digests_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/md5_pkg.sv
sv/md5_front.sv
sv/md5_back.sv
sv/md5_message_digest.sv
dv/md5_digest_checker.sv
dv/tb.sv
